[rtl/core/irpdt_pkg.sv]
// ----------------------------------------------------------------------------
// IR pulse-distance transmitter package
// Shared types, register indexes and the key code table.
// ----------------------------------------------------------------------------
`default_nettype none

package irpdt_pkg;

    localparam int LEN_W   = 17;
    localparam int KEY_W   = 6;
    localparam int CODE_W  = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_MARK  = 3'd0,
        REG_HEADER_SPACE = 3'd1,
        REG_BIT_MARK     = 3'd2,
        REG_ZERO_SPACE   = 3'd3,
        REG_ONE_SPACE    = 3'd4,
        REG_FRAME_GAP    = 3'd5
    } cfg_reg_t;

    localparam len_t HEADER_MARK_RST  = 17'd9000;
    localparam len_t HEADER_SPACE_RST = 17'd4500;
    localparam len_t BIT_MARK_RST     = 17'd500;
    localparam len_t ZERO_SPACE_RST   = 17'd500;
    localparam len_t ONE_SPACE_RST    = 17'd1620;
    localparam len_t FRAME_GAP_RST    = 17'd100000;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HMARK  = 3'd1,
        PH_HSPACE = 3'd2,
        PH_BMARK  = 3'd3,
        PH_BSPACE = 3'd4,
        PH_GAP    = 3'd5
    } phase_t;

    typedef struct packed {
        logic  valid;
        code_t code;
    } key_entry_t;

    function automatic key_entry_t key_lookup(input key_t key);
        key_entry_t e;
        e.valid = 1'b1;
        case (key)
            6'd0:    e.code = 32'h0af530cf;
            6'd1:    e.code = 32'h0af5b04f;
            6'd2:    e.code = 32'h0af5708f;
            6'd3:    e.code = 32'h0af5f00f;
            6'd4:    e.code = 32'h0af538c7;
            6'd5:    e.code = 32'h0af5b847;
            6'd6:    e.code = 32'h0af57887;
            6'd7:    e.code = 32'h0af5f807;
            6'd8:    e.code = 32'h0af520df;
            6'd9:    e.code = 32'h0af5a05f;
            6'd10:   e.code = 32'h0af548b7;
            6'd11:   e.code = 32'h0af5a857;
            6'd12:   e.code = 32'h0af5d02f;
            6'd13:   e.code = 32'h0af59867;
            6'd14:   e.code = 32'h0af518e7;
            6'd15:   e.code = 32'h0af5e817;
            6'd17:   e.code = 32'h0af550af;
            6'd20:   e.code = 32'h0af508f7;
            6'd21:   e.code = 32'h0af50ef1;
            6'd22:   e.code = 32'h0af58e71;
            6'd23:   e.code = 32'h0af5ce31;
            6'd24:   e.code = 32'h0af54eb1;
            6'd25:   e.code = 32'h0af5748b;
            6'd26:   e.code = 32'h0af532cd;
            6'd27:   e.code = 32'h0af5a25d;
            6'd28:   e.code = 32'h0af5629d;
            6'd29:   e.code = 32'h0af5e21d;
            6'd36:   e.code = 32'h0af5906f;
            default:
            begin
                e.valid = 1'b0;
                e.code  = '0;
            end
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

[rtl/core/irpdt_if.sv]
// ----------------------------------------------------------------------------
// IR pulse-distance transmitter channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface irpdt_item_if;
    import irpdt_pkg::*;
    logic valid;
    logic ready;
    logic op;
    key_t key;
    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface irpdt_result_if;
    logic valid;
    logic ready;
    logic ir_level;
    logic active;
    logic key_error;
    logic frame_start;
    modport source (output valid, output ir_level, output active, output key_error,
                    output frame_start, input ready);
    modport sink   (input valid, input ir_level, input active, input key_error,
                    input frame_start, output ready);
endinterface

interface irpdt_cfg_if;
    import irpdt_pkg::*;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    len_t     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/ir_pulse_distance_transmitter_unit.sv]
// ----------------------------------------------------------------------------
// IR pulse-distance transmitter
// Steps a header/bit/gap envelope one tick per tick item.
// ----------------------------------------------------------------------------
// Usage: every transfer on the item channel is either a tick (op 0) or a
// key selection (op 1). Each item produces exactly one result on the result
// channel carrying the envelope level for that tick, the active and error
// flags, and a frame-start strobe on the tick where a header mark begins.
// A selection looks the key up in a fixed code table and restarts the frame;
// an unknown key stops sending and sets key_error until a valid selection.
// The result is registered in the cycle after its item transfer. Throughput
// is one item per cycle when not stalled: the phase counter and phase
// decode sit between the state registers and the single output register.
// If the receiver stalls, the output register holds its result and the
// item channel accepts a new item only in the cycle the held result is
// taken. The register write channel is always ready; lengths of zero count
// as one tick. Reset loads the default lengths, goes idle and clears the
// error flag and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_transmitter_unit #(
    parameter int CODE_BITS = 32
) (
    input  wire               clk,
    input  wire               rst_n,
    irpdt_item_if.sink        item,
    irpdt_result_if.source    result,
    irpdt_cfg_if.sink         cfg
);
    import irpdt_pkg::*;

    localparam int BIT_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(CODE_BITS - 1);

    // Length registers
    len_t hmark_reg, hspace_reg, bmark_reg, zspace_reg, ospace_reg, gap_reg;

    // Sequencer state
    phase_t                phase_reg, phase_next;
    logic [BIT_W-1:0]      bit_index_reg, bit_index_next;
    len_t                  ticks_left_reg, ticks_left_next;
    logic [CODE_BITS-1:0]  frame_code_reg, frame_code_next;
    logic                  err_reg, err_next;

    // Output register
    logic out_valid_reg;
    logic level_reg, active_reg, err_out_reg, fstart_reg;
    logic level_next, fstart_next;

    logic       accept;
    key_entry_t entry;
    len_t       phase_len;
    len_t       ticks_cur;
    len_t       ticks_dec;
    logic       load;
    logic       cur_bit;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign entry   = key_lookup(item.key);
    assign cur_bit = frame_code_reg[LAST_BIT - bit_index_reg];

    always_comb
    begin
        len_t raw;
        unique case (phase_reg)
            PH_HMARK:  raw = hmark_reg;
            PH_HSPACE: raw = hspace_reg;
            PH_BMARK:  raw = bmark_reg;
            PH_BSPACE: raw = cur_bit ? ospace_reg : zspace_reg;
            default:   raw = gap_reg;
        endcase
        phase_len = (raw == '0) ? len_t'(1) : raw;
    end

    assign load      = (ticks_left_reg == '0);
    assign ticks_cur = load ? phase_len : ticks_left_reg;
    assign ticks_dec = ticks_cur - len_t'(1);

    // Next state for one accepted item.
    always_comb
    begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        ticks_left_next = ticks_left_reg;
        frame_code_next = frame_code_reg;
        err_next        = err_reg;
        if (accept)
        begin
            if (item.op)
            begin
                ticks_left_next = '0;
                if (entry.valid)
                begin
                    frame_code_next = entry.code[CODE_BITS-1:0];
                    phase_next      = PH_HMARK;
                    bit_index_next  = '0;
                    err_next        = 1'b0;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    err_next   = 1'b1;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                ticks_left_next = ticks_dec;
                if (ticks_dec == '0)
                begin
                    unique case (phase_reg)
                        PH_HMARK:  phase_next = PH_HSPACE;
                        PH_HSPACE:
                        begin
                            phase_next     = PH_BMARK;
                            bit_index_next = '0;
                        end
                        PH_BMARK:  phase_next = PH_BSPACE;
                        PH_BSPACE:
                        begin
                            if (bit_index_reg >= LAST_BIT)
                            begin
                                phase_next = PH_GAP;
                            end
                            else
                            begin
                                bit_index_next = bit_index_reg + BIT_W'(1);
                                phase_next     = PH_BMARK;
                            end
                        end
                        default:   phase_next = PH_HMARK;
                    endcase
                end
            end
        end
    end

    // Result values for the tick being processed.
    always_comb
    begin
        level_next  = 1'b0;
        fstart_next = 1'b0;
        if (!item.op && phase_reg != PH_IDLE)
        begin
            level_next  = (phase_reg == PH_HMARK) || (phase_reg == PH_BMARK);
            fstart_next = load && (phase_reg == PH_HMARK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= '0;
            ticks_left_reg <= '0;
            frame_code_reg <= '0;
            err_reg        <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            ticks_left_reg <= ticks_left_next;
            frame_code_reg <= frame_code_next;
            err_reg        <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hmark_reg  <= HEADER_MARK_RST;
            hspace_reg <= HEADER_SPACE_RST;
            bmark_reg  <= BIT_MARK_RST;
            zspace_reg <= ZERO_SPACE_RST;
            ospace_reg <= ONE_SPACE_RST;
            gap_reg    <= FRAME_GAP_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            // Indexes past the last register are dropped.
            case (cfg.index)
                REG_HEADER_MARK:  hmark_reg  <= cfg.data;
                REG_HEADER_SPACE: hspace_reg <= cfg.data;
                REG_BIT_MARK:     bmark_reg  <= cfg.data;
                REG_ZERO_SPACE:   zspace_reg <= cfg.data;
                REG_ONE_SPACE:    ospace_reg <= cfg.data;
                REG_FRAME_GAP:    gap_reg    <= cfg.data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg   <= level_next;
            active_reg  <= (phase_next != PH_IDLE);
            err_out_reg <= err_next;
            fstart_reg  <= fstart_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.ir_level    = level_reg;
    assign result.active      = active_reg;
    assign result.key_error   = err_out_reg;
    assign result.frame_start = fstart_reg;

endmodule

`default_nettype wire

[sim/irpdt_envelope_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IR pulse-distance transmitter envelope checker
// Watches the item, result and register write channels of the transmitter,
// predicts the envelope result of every accepted item from its own copy of
// the phase state and the lengths, and compares each result field by field.
// ----------------------------------------------------------------------------

package irpdt_tb_pkg;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SELECT = 1'b1;

endpackage

module irpdt_envelope_checker (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    input  wire                 item_ready,
    input  wire                 item_op,
    input  irpdt_pkg::key_t     item_key,
    input  wire                 res_valid,
    input  wire                 res_ready,
    input  wire                 res_ir_level,
    input  wire                 res_active,
    input  wire                 res_key_error,
    input  wire                 res_frame_start,
    input  wire                 cfg_valid,
    input  wire                 cfg_ready,
    input  irpdt_pkg::cfg_idx_t cfg_index,
    input  irpdt_pkg::len_t     cfg_data,
    output int                  mismatch_count,
    output int                  pending_results
);
    import irpdt_pkg::*;
    import irpdt_tb_pkg::*;

    typedef struct packed {
        logic ir_level;
        logic active;
        logic key_error;
        logic frame_start;
    } envelope_t;

    // Bit k is set when key k has a code.
    localparam logic [63:0] KEY_PRESENT = 64'h0000_0010_3FF2_FFFF;

    localparam code_t KEY_CODES [64] = '{
        0: 32'h0af530cf,  1: 32'h0af5b04f,  2: 32'h0af5708f,  3: 32'h0af5f00f,
        4: 32'h0af538c7,  5: 32'h0af5b847,  6: 32'h0af57887,  7: 32'h0af5f807,
        8: 32'h0af520df,  9: 32'h0af5a05f, 10: 32'h0af548b7, 11: 32'h0af5a857,
        12: 32'h0af5d02f, 13: 32'h0af59867, 14: 32'h0af518e7, 15: 32'h0af5e817,
        17: 32'h0af550af, 20: 32'h0af508f7, 21: 32'h0af50ef1, 22: 32'h0af58e71,
        23: 32'h0af5ce31, 24: 32'h0af54eb1, 25: 32'h0af5748b, 26: 32'h0af532cd,
        27: 32'h0af5a25d, 28: 32'h0af5629d, 29: 32'h0af5e21d, 36: 32'h0af5906f,
        default: 32'h0
    };

    phase_t      ph;
    logic [4:0]  bit_idx;
    len_t        ticks_left;
    code_t       frame_code;
    logic        err_flag;
    len_t        lengths [6];
    envelope_t   expected_envelopes [$];
    int          result_seq;

    task automatic report_mismatch(input string text);
        $display("[%0t] envelope mismatch: %s", $time, text);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic got_val, input logic want_val);
        if (got_val !== want_val)
            report_mismatch($sformatf("result %0d %s got %b expected %b",
                                      result_seq, name, got_val, want_val));
    endtask

    function automatic len_t phase_len();
        len_t v;
        case (ph)
            PH_HMARK:  v = lengths[REG_HEADER_MARK];
            PH_HSPACE: v = lengths[REG_HEADER_SPACE];
            PH_BMARK:  v = lengths[REG_BIT_MARK];
            PH_BSPACE: v = frame_code[CODE_W - 1 - bit_idx] ? lengths[REG_ONE_SPACE]
                                                            : lengths[REG_ZERO_SPACE];
            default:   v = lengths[REG_FRAME_GAP];
        endcase
        // A programmed length of zero still lasts one tick.
        return (v == '0) ? len_t'(1) : v;
    endfunction

    task automatic advance_phase();
        case (ph)
            PH_HMARK:  ph = PH_HSPACE;
            PH_HSPACE:
            begin
                ph      = PH_BMARK;
                bit_idx = '0;
            end
            PH_BMARK:  ph = PH_BSPACE;
            PH_BSPACE:
            begin
                if (bit_idx >= CODE_W - 1)
                    ph = PH_GAP;
                else
                begin
                    bit_idx = bit_idx + 1'b1;
                    ph      = PH_BMARK;
                end
            end
            default:   ph = PH_HMARK;
        endcase
    endtask

    task automatic step_envelope(input logic op, input key_t key, output envelope_t env);
        env = '0;
        if (op == OP_SELECT)
        begin
            if (KEY_PRESENT[key])
            begin
                frame_code = KEY_CODES[key];
                ph         = PH_HMARK;
                bit_idx    = '0;
                ticks_left = '0;
                err_flag   = 1'b0;
            end
            else
            begin
                // The stored code survives an unknown key.
                ph         = PH_IDLE;
                ticks_left = '0;
                err_flag   = 1'b1;
            end
        end
        else if (ph != PH_IDLE)
        begin
            if (ticks_left == '0)
            begin
                ticks_left      = phase_len();
                env.frame_start = (ph == PH_HMARK);
            end
            env.ir_level = (ph == PH_HMARK) || (ph == PH_BMARK);
            ticks_left   = ticks_left - 1'b1;
            if (ticks_left == '0)
                advance_phase();
        end
        env.active    = (ph != PH_IDLE);
        env.key_error = err_flag;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        envelope_t got;
        envelope_t want;
        if (!rst_n)
        begin
            ph                        = PH_IDLE;
            bit_idx                   = '0;
            ticks_left                = '0;
            frame_code                = '0;
            err_flag                  = 1'b0;
            lengths[REG_HEADER_MARK]  = HEADER_MARK_RST;
            lengths[REG_HEADER_SPACE] = HEADER_SPACE_RST;
            lengths[REG_BIT_MARK]     = BIT_MARK_RST;
            lengths[REG_ZERO_SPACE]   = ZERO_SPACE_RST;
            lengths[REG_ONE_SPACE]    = ONE_SPACE_RST;
            lengths[REG_FRAME_GAP]    = FRAME_GAP_RST;
            expected_envelopes.delete();
            result_seq                = 0;
            mismatch_count            = 0;
        end
        else
        begin
            // Writes to indexes past the last length register are dropped.
            if (cfg_valid && cfg_ready && cfg_index <= REG_FRAME_GAP)
                lengths[cfg_index] = cfg_data;

            if (res_valid && res_ready)
            begin
                got = {res_ir_level, res_active, res_key_error, res_frame_start};
                if (expected_envelopes.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                              result_seq));
                else
                begin
                    want = expected_envelopes.pop_front();
                    check_field("ir_level", got.ir_level, want.ir_level);
                    check_field("active", got.active, want.active);
                    check_field("key_error", got.key_error, want.key_error);
                    check_field("frame_start", got.frame_start, want.frame_start);
                end
                result_seq++;
            end

            if (item_valid && item_ready)
            begin
                step_envelope(item_op, item_key, want);
                expected_envelopes.push_back(want);
            end
        end
        pending_results = expected_envelopes.size();
    end

endmodule

[sim/ir_pulse_distance_transmitter_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IR pulse-distance transmitter testbench
// Drives ticks and key selections through the item channel under several
// length settings and idle patterns, with a long result hold-off and a full
// drain along the way; the envelope checker judges every result.
// ----------------------------------------------------------------------------

module ir_pulse_distance_transmitter_unit_tb;
    import irpdt_pkg::*;
    import irpdt_tb_pkg::*;

    localparam int       CYCLE_LIMIT     = 200000;
    localparam int       HOLD_OFF_CYCLES = 300;
    localparam int       DRAIN_CYCLES    = 4;
    localparam int       RANDOM_PHASES   = 8;
    localparam cfg_idx_t SPARE_INDEX_LO  = 3'd6;
    localparam cfg_idx_t SPARE_INDEX_HI  = 3'd7;
    localparam len_t     LEN_MAX         = '1;
    localparam len_t     LEN_ONE         = 17'd1;

    logic clk;
    logic rst_n;

    int   mismatch_count;
    int   pending_results;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_seq;
    int   cycle_count;
    bit   stopped;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    irpdt_item_if   item_ch ();
    irpdt_result_if result_ch ();
    irpdt_cfg_if    cfg_ch ();

    ir_pulse_distance_transmitter_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    irpdt_envelope_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_ch.valid),
        .item_ready      (item_ch.ready),
        .item_op         (item_ch.op),
        .item_key        (item_ch.key),
        .res_valid       (result_ch.valid),
        .res_ready       (result_ch.ready),
        .res_ir_level    (result_ch.ir_level),
        .res_active      (result_ch.active),
        .res_key_error   (result_ch.key_error),
        .res_frame_start (result_ch.frame_start),
        .cfg_valid       (cfg_ch.valid),
        .cfg_ready       (cfg_ch.ready),
        .cfg_index       (cfg_ch.index),
        .cfg_data        (cfg_ch.data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Result side: random stalls, plus a long hold-off whenever hold_seq moves.
    initial
    begin : result_sink
        int seen_seq;
        seen_seq        = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != seen_seq)
            begin
                seen_seq        = hold_seq;
                result_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ir_pulse_distance_transmitter_unit_tb failed");
        $finish;
    end

    // Called right after a falling edge; returns after the transfer with valid still high.
    task automatic send_item(input logic op, input key_t key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid = 1'b1;
        item_ch.op    = op;
        item_ch.key   = key;
        do @(posedge clk); while (!item_ch.ready);
        @(negedge clk);
    endtask

    task automatic select_key(input bit known);
        key_t       k;
        key_entry_t entry;
        do
        begin
            k     = key_t'($urandom_range(63));
            entry = key_lookup(k);
        end
        while (entry.valid != known);
        stopped = !known;
        send_item(OP_SELECT, k);
    endtask

    // Mostly ticks; selections are rare so that whole frames and repeats play out.
    // After an unknown key the block sits idle, so a fresh selection comes soon.
    task automatic send_random_item();
        int unsigned r;
        r = $urandom_range(999);
        if (r < (stopped ? 150 : 5))
            select_key(1'b1);
        else if (r >= 996)
            select_key(1'b0);
        else
            send_item(OP_TICK, key_t'($urandom_range(63)));
    endtask

    task automatic wait_idle();
        item_ch.valid = 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    task automatic write_length(input cfg_idx_t idx, input len_t value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    task automatic program_lengths(input len_t hm, input len_t hs, input len_t bm,
                                   input len_t zs, input len_t os, input len_t gap);
        wait_idle();
        write_length(REG_HEADER_MARK, hm);
        write_length(REG_HEADER_SPACE, hs);
        write_length(REG_BIT_MARK, bm);
        write_length(REG_ZERO_SPACE, zs);
        write_length(REG_ONE_SPACE, os);
        write_length(REG_FRAME_GAP, gap);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic len_t rand_len(input int unsigned lo, input int unsigned hi);
        return len_t'($urandom_range(hi, lo));
    endfunction

    initial
    begin : stimulus
        int n_items;
        rst_n          = 1'b0;
        item_ch.valid  = 1'b0;
        item_ch.op     = OP_TICK;
        item_ch.key    = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stopped        = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Default lengths: idle ticks, unknown keys, a restart while sending.
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '1);
        send_item(OP_SELECT, 6'd16);
        send_item(OP_TICK, 6'd5);
        send_item(OP_SELECT, '1);
        send_item(OP_SELECT, '0);
        repeat (3) send_item(OP_TICK, '0);
        send_item(OP_SELECT, 6'd36);
        send_item(OP_TICK, 6'd42);
        send_item(OP_SELECT, 6'd18);
        send_item(OP_TICK, '0);

        // Zero lengths behave as one tick; writes past the last register do nothing.
        program_lengths('0, '0, '0, '0, '0, '0);
        write_length(SPARE_INDEX_LO, LEN_MAX);
        write_length(SPARE_INDEX_HI, LEN_MAX);
        cfg_ch.valid = 1'b0;
        send_item(OP_SELECT, 6'd15);
        repeat (12) send_item(OP_TICK, key_t'($urandom_range(63)));

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: program_lengths(LEN_ONE, LEN_ONE, LEN_ONE, LEN_ONE, LEN_ONE, LEN_ONE);
                3: program_lengths(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
                4: program_lengths(rand_len(0, 3), rand_len(0, 3), rand_len(0, 3),
                                   rand_len(0, 3), rand_len(0, 3), rand_len(0, 3));
                5: program_lengths(rand_len(1, 6), rand_len(1, 6), rand_len(1, 6),
                                   rand_len(1, 6), rand_len(1, 6), rand_len(1, 40));
                6: program_lengths(rand_len(1, 2), rand_len(1, 2), rand_len(1, 2),
                                   rand_len(1, 2), rand_len(1, 2), rand_len(1, 2));
                default: program_lengths(rand_len(1, 4), rand_len(1, 4), rand_len(1, 4),
                                         rand_len(1, 4), rand_len(1, 4), rand_len(1, 4));
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 46;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 46;
                end
                default:
                begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
            endcase
            n_items = (p == 3) ? 30 : 145;
            select_key(1'b1);
            for (int i = 1; i < n_items; i++)
            begin
                // Hold off results while items keep coming, so the input backs up.
                if (p == 1 && i == 40)
                    hold_seq++;
                if (p == 2 && i == 70)
                    wait_idle();
                send_random_item();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("ir_pulse_distance_transmitter_unit_tb passed");
        else
            $display("ir_pulse_distance_transmitter_unit_tb failed");
        $finish;
    end

endmodule
